@@ hdl/stratified_grid_sample_generator_core_assert.svh @@
// Assertion macros for the checker file.
`ifndef STRATIFIED_GRID_SAMPLE_GENERATOR_CORE_ASSERT_SVH
`define STRATIFIED_GRID_SAMPLE_GENERATOR_CORE_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define SGS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define SGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sgsg_pkg.sv @@
`timescale 1ns / 1ps
package sgsg_pkg;

  localparam int unsigned MaxCellsDefault = 256;
  localparam int unsigned CoordFracDefault = 16;
  localparam int unsigned JitterFracDefault = 16;
  localparam int unsigned NumAxes = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned CountW = 9;

  localparam logic [CfgIdxW-1:0] RegPixCellsU = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPixCellsV = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLensCellsU = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLensCellsV = 3'd3;
  localparam logic [CfgIdxW-1:0] RegJitPix = 3'd4;
  localparam logic [CfgIdxW-1:0] RegJitLens = 3'd5;

  localparam logic KindPrepare = 1'b0;
  localparam logic KindSample = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [31:0]        samp_num;
    logic signed [31:0] pix_lo_u;
    logic signed [31:0] pix_hi_u;
    logic signed [31:0] pix_lo_v;
    logic signed [31:0] pix_hi_v;
    logic signed [31:0] lens_lo_u;
    logic signed [31:0] lens_hi_u;
    logic signed [31:0] lens_lo_v;
    logic signed [31:0] lens_hi_v;
    logic [63:0]        jitter_bits;
  } sgsg_in_t;

  typedef struct packed {
    logic [32:0]        sample_count;
    logic signed [31:0] pix_u;
    logic signed [31:0] pix_v;
    logic signed [31:0] lens_u;
    logic signed [31:0] lens_v;
  } sgsg_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StDiv,
    StMul,
    StAxisDone,
    StOut
  } sgsg_state_e;

  // Handshake between the sequencer and the bit-serial divider.
  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [8:0]  divisor;
  } sgsg_div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quotient;
    logic [8:0]  remainder;
  } sgsg_div_rsp_t;

endpackage

@@ hdl/stratified_grid_sample_generator_core.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake                 | Payload
// --------+-----------+---------------------------+------------
// input   | in        | in_valid_i / in_ready_o   | sgsg_in_t
// output  | out       | out_valid_o / out_ready_i | sgsg_out_t
// config  | in        | cfg_we_i                  | index, data
// One item at a time. Each axis runs a bit-serial divide and then a serial
// multiply one bit per cycle.
// Reset restores unit bounds, zero widths and a single cell on every axis.
// A waiting result is held in the output register and input is refused until it
// is taken, so an output stall also holds off the next item.
module stratified_grid_sample_generator_core import sgsg_pkg::*; #(
  parameter int unsigned MAX_CELLS_PER_AXIS = MaxCellsDefault,
  parameter int unsigned COORD_FRAC_BITS = CoordFracDefault,
  parameter int unsigned JITTER_FRAC_BITS = JitterFracDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sgsg_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sgsg_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  localparam int unsigned MulW = CountW + JITTER_FRAC_BITS;

  sgsg_state_e state_q, state_d;
  logic [1:0]  axis_q, axis_d;
  logic        kind_q;
  logic [32:0] acc_q, acc_d;       // running quotient or sample count
  logic signed [63:0] term_q, term_d;
  logic [63:0] jit_q;
  logic [CountW-1:0] cells_q [NumAxes];
  logic        jpix_q, jlens_q;
  logic signed [31:0] blo_q [NumAxes];
  logic signed [31:0] bhi_q [NumAxes];
  logic signed [31:0] lo_q [NumAxes];
  logic signed [31:0] hi_q [NumAxes];
  logic signed [31:0] wid_q [NumAxes];
  logic [CountW-1:0]  act_q [NumAxes];
  logic signed [31:0] res_q [NumAxes];
  logic        out_valid_q;
  sgsg_out_t   out_q;

  sgsg_div_req_t div_req;
  sgsg_div_rsp_t div_rsp;
  logic        mul_start, mul_done;
  logic [63:0] prod;
  logic [63:0] pshift;
  logic [32:0] mcand;
  logic [MulW-1:0] mplier;

  logic signed [32:0] span, qmag, wq, wext;
  logic [32:0] mag, wabs;
  logic signed [31:0] wid_new;
  logic [CountW-1:0] act_new;
  logic [CountW-1:0] cfg_sat;
  logic        jit_on;
  logic [15:0] jfield;
  logic [JITTER_FRAC_BITS-1:0] frac;
  logic signed [63:0] x;
  logic        take_in;

  assign in_ready_o = (state_q == StIdle) && !out_valid_q;
  assign take_in    = in_valid_i && in_ready_o;

  always_comb begin
    cfg_sat = cfg_data_i;
    if (cfg_data_i == '0) cfg_sat = CountW'(1);
    if (32'(cfg_data_i) > MAX_CELLS_PER_AXIS) cfg_sat = CountW'(MAX_CELLS_PER_AXIS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NumAxes; a++) cells_q[a] <= CountW'(1);
      jpix_q  <= 1'b0;
      jlens_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPixCellsU:  cells_q[0] <= cfg_sat;
        RegPixCellsV:  cells_q[1] <= cfg_sat;
        RegLensCellsU: cells_q[2] <= cfg_sat;
        RegLensCellsV: cells_q[3] <= cfg_sat;
        RegJitPix:     jpix_q <= cfg_data_i[0];
        RegJitLens:    jlens_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The whole input transaction is captured when it is accepted.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      blo_q[0] <= in_data_i.pix_lo_u;  bhi_q[0] <= in_data_i.pix_hi_u;
      blo_q[1] <= in_data_i.pix_lo_v;  bhi_q[1] <= in_data_i.pix_hi_v;
      blo_q[2] <= in_data_i.lens_lo_u; bhi_q[2] <= in_data_i.lens_hi_u;
      blo_q[3] <= in_data_i.lens_lo_v; bhi_q[3] <= in_data_i.lens_hi_v;
      kind_q   <= in_data_i.kind;
      jit_q    <= in_data_i.jitter_bits;
    end
  end

  // The width is divided as a magnitude and the sign restored afterwards,
  // which truncates toward zero.
  assign span    = 33'(bhi_q[axis_q]) - 33'(blo_q[axis_q]);
  assign mag     = span[32] ? -span : span;
  assign qmag    = $signed(div_rsp.quotient);
  assign wq      = span[32] ? -qmag : qmag;
  assign wid_new = (wq > 33'sd2147483647) ? 32'sh7fffffff :
                   (wq < -33'sd2147483648) ? 32'sh80000000 : wq[31:0];
  assign act_new = (blo_q[axis_q] == bhi_q[axis_q]) ? CountW'(1) : cells_q[axis_q];

  assign jit_on = axis_q[1] ? jlens_q : jpix_q;
  assign jfield = jit_q[16*axis_q +: 16];
  assign frac   = jit_on ? jfield[15 -: JITTER_FRAC_BITS]
                         : {1'b1, {(JITTER_FRAC_BITS-1){1'b0}}};
  assign wext   = 33'(wid_q[axis_q]);
  assign wabs   = wext[32] ? -wext : wext;

  // A sample multiplies |width| by the cell index and fraction in one pass, so
  // that the shifted product is index * |width| plus the truncated offset.
  always_comb begin
    div_req.start    = (state_q == StLoad);
    div_req.dividend = (kind_q == KindPrepare) ? mag : acc_q;
    div_req.divisor  = (kind_q == KindPrepare) ? cells_q[axis_q] : act_q[axis_q];
    mul_start        = (state_q == StDiv) && div_rsp.done;
    mcand            = (kind_q == KindPrepare) ? acc_q : wabs;
    mplier           = (kind_q == KindPrepare) ? MulW'(act_new) : {div_rsp.remainder, frac};
  end

  sgsg_divider u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  sgsg_serial_mul #(.MW(MulW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start),
    .mcand_i(mcand), .mplier_i(mplier), .done_o(mul_done), .prod_o(prod)
  );

  assign pshift = prod >> JITTER_FRAC_BITS;

  always_comb begin
    x = 64'(lo_q[axis_q]) + term_q;
    if (x > 64'(hi_q[axis_q])) x = 64'(hi_q[axis_q]);
    if (x < 64'(lo_q[axis_q])) x = 64'(lo_q[axis_q]);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:     if (take_in) state_d = StLoad;
      StLoad:     state_d = StDiv;
      StDiv:      if (div_rsp.done) state_d = StMul;
      StMul:      if (mul_done) state_d = StAxisDone;
      StAxisDone: state_d = (axis_q == 2'd3) ? StOut : StLoad;
      StOut:      state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  // Datapath updates.
  always_comb begin
    axis_d = axis_q;
    acc_d  = acc_q;
    term_d = term_q;
    case (state_q)
      StIdle: begin
        axis_d = 2'd0;
        if (take_in) begin
          acc_d = (in_data_i.kind == KindPrepare) ? 33'd1 : {1'b0, in_data_i.samp_num};
        end
      end
      StDiv:      if (div_rsp.done && kind_q != KindPrepare) acc_d = div_rsp.quotient;
      StMul: begin
        if (mul_done) begin
          if (kind_q == KindPrepare) begin
            acc_d = prod[32:0];
          end else begin
            term_d = wid_q[axis_q][31] ? -$signed(pshift) : $signed(pshift);
          end
        end
      end
      StAxisDone: axis_d = axis_q + 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      axis_q  <= '0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < NumAxes; a++) begin
        lo_q[a]  <= '0;
        hi_q[a]  <= 32'sd1 <<< COORD_FRAC_BITS;
        wid_q[a] <= '0;
        act_q[a] <= CountW'(1);
      end
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == StOut) out_valid_q <= 1'b1;
      if (state_q == StDiv && div_rsp.done && kind_q == KindPrepare) begin
        lo_q[axis_q]  <= blo_q[axis_q];
        hi_q[axis_q]  <= bhi_q[axis_q];
        act_q[axis_q] <= act_new;
        wid_q[axis_q] <= wid_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    term_q <= term_d;
    if (state_q == StAxisDone && kind_q != KindPrepare) res_q[axis_q] <= x[31:0];
    if (state_q == StOut) begin
      out_q.sample_count <= (kind_q == KindPrepare) ? acc_q : '0;
      out_q.pix_u  <= (kind_q == KindPrepare) ? '0 : res_q[0];
      out_q.pix_v  <= (kind_q == KindPrepare) ? '0 : res_q[1];
      out_q.lens_u <= (kind_q == KindPrepare) ? '0 : res_q[2];
      out_q.lens_v <= (kind_q == KindPrepare) ? '0 : res_q[3];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

@@ hdl/sgsg_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, unsigned 33-bit by 9-bit.
module sgsg_divider import sgsg_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sgsg_div_req_t req_i,
  output sgsg_div_rsp_t rsp_o
);
  logic [32:0] quo_q, quo_d;
  logic [9:0]  rem_q, rem_d;
  logic [8:0]  dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [9:0]  trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[8:0], quo_q[32]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 6'd33;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q[8:0];
endmodule

@@ hdl/sgsg_serial_mul.sv @@
`timescale 1ns / 1ps
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
module sgsg_serial_mul #(
  parameter int unsigned MW = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [32:0]   mcand_i,
  input  logic [MW-1:0] mplier_i,
  output logic          done_o,
  output logic [63:0]   prod_o
);
  localparam int unsigned CW = $clog2(MW + 1);
  logic [63:0]   acc_q, acc_d, sh_q, sh_d;
  logic [MW-1:0] mp_q, mp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;

  always_comb begin
    acc_d  = acc_q;
    sh_d   = sh_q;
    mp_d   = mp_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      sh_d   = 64'(mcand_i);
      mp_d   = mplier_i;
      cnt_d  = CW'(MW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_d = acc_q + sh_q;
      end
      sh_d  = sh_q << 1;
      mp_d  = mp_q >> 1;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    mp_q  <= mp_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule

@@ hdl/sgsg_checker.sv @@
`timescale 1ns / 1ps
`include "stratified_grid_sample_generator_core_assert.svh"
module sgsg_checker import sgsg_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input sgsg_out_t out_data_i
);
  `SGS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `SGS_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_data_i), "result changed while stalled")
  `SGS_ASSERT_IMPL(a_busy_when_out, out_valid_i, !in_ready_i, "input taken while result waits")
  `SGS_ASSERT_NEXT(a_no_instant, in_valid_i && in_ready_i, !out_valid_i, "result before work done")
endmodule

bind stratified_grid_sample_generator_core sgsg_checker u_sgsg_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .out_valid_i(out_valid_o),
  .out_ready_i, .out_data_i(out_data_o)
);
